/* rtl/pgp_pkg.sv */
// Shared types, widths and register codes for the pixel to ground plane projection block.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package pgp_pkg;

  localparam int PIX_W      = 24;
  localparam int FOC_W      = 32;
  localparam int ROW_W      = 60;
  localparam int F_W        = 20;   // one packed Q1.18 / Q8.12 field
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;
  localparam int RAY_W      = 42;   // ray x, y with 24 fraction bits
  localparam int PROD_W     = RAY_W + F_W;
  localparam int A_W        = 63;   // rotated ray, 42 fraction bits
  localparam int DEN_W      = A_W - 1;
  localparam int NUM_W      = F_W;
  localparam int Q_W        = 33;
  localparam int DIV_STEPS  = NUM_W + 46;
  localparam int M_W        = 52;
  localparam int OUT_W      = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW0    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW1    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW2    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_WORLD_OFFSET = 4'd7;

  typedef struct packed {
    logic [PIX_W-1:0] center_x;
    logic [PIX_W-1:0] center_y;
    logic [FOC_W-1:0] inv_focal_x;
    logic [FOC_W-1:0] inv_focal_y;
    logic [ROW_W-1:0] rot_row0;
    logic [ROW_W-1:0] rot_row1;
    logic [ROW_W-1:0] rot_row2;
    logic [ROW_W-1:0] world_offset;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    center_x:     24'd163798,
    center_y:     24'd131131,
    inv_focal_x:  32'd2677461,
    inv_focal_y:  32'd2676354,
    rot_row0:     '0,
    rot_row1:     '0,
    rot_row2:     '0,
    world_offset: '0
  };

  typedef struct packed {
    logic [PIX_W-1:0] pixel_u;
    logic [PIX_W-1:0] pixel_v;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] world_x;
    logic signed [OUT_W-1:0] world_y;
    logic signed [OUT_W-1:0] world_z;
    logic signed [OUT_W-1:0] ray_depth;
    logic                    parallel_ray;
    logic                    saturated;
  } out_word_t;

  // en: whole pipe may shift; down_load: first stage downstream takes a word
  typedef struct packed {
    logic en;
    logic down_load;
  } pipe_ctl_t;

  typedef struct packed {
    logic [NUM_W-1:0]      num;   // |w.z|
    logic [DEN_W-1:0]      den;   // |a2|
    logic signed [A_W-1:0] a0;
    logic signed [A_W-1:0] a1;
    logic signed [A_W-1:0] a2;
    logic                  neg;
    logic                  par;
  } div_in_t;

  typedef struct packed {
    div_in_t          op;
    logic [DEN_W-1:0] rem;
    logic [Q_W-1:0]   q;
    logic             ovf;
  } div_st_t;

  function automatic logic signed [F_W-1:0] field20(input logic [ROW_W-1:0] packed_v,
                                                     input int k);
    field20 = $signed(packed_v[F_W*k +: F_W]);
  endfunction

endpackage

/* rtl/pgp_ray.sv */
// Front pipeline: pixel offset, focal scaling, rounding, rotation and divider operand prep.
// Depends on pgp_pkg.
module pgp_ray (
  input  logic              clk,
  input  logic              rst_n,
  input  pgp_pkg::pipe_ctl_t ctl,
  input  pgp_pkg::cfg_t     cfg,
  input  logic              v_in,
  input  pgp_pkg::in_word_t d_in,
  output logic              up_load,
  output logic              v_out,
  output pgp_pkg::div_in_t  d_out
);

  localparam int N = 6;

  logic [N-1:0] v_r, v_nxt, ld, v_prev, ld_next;

  assign ld      = {N{ctl.en}} | ~v_r;
  assign v_prev  = {v_r[N-2:0], v_in};
  assign ld_next = {ctl.down_load, ld[N-1:1]};
  assign v_nxt   = (ld & v_prev) | (~ld & ~ld_next);
  assign up_load = ld[0];
  assign v_out   = v_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // stage 1: offsets from principal point
  logic signed [pgp_pkg::PIX_W:0] du_r, dv_r;
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      du_r <= $signed({1'b0, d_in.pixel_u}) - $signed({1'b0, cfg.center_x});
      dv_r <= $signed({1'b0, d_in.pixel_v}) - $signed({1'b0, cfg.center_y});
    end
  end

  // stage 2: scale by inverse focal length, 40 fraction bits
  localparam int PX_W = pgp_pkg::PIX_W + pgp_pkg::FOC_W + 2;
  logic signed [PX_W-1:0] px_r, py_r;
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      px_r <= du_r * $signed({1'b0, cfg.inv_focal_x});
      py_r <= dv_r * $signed({1'b0, cfg.inv_focal_y});
    end
  end

  // stage 3: round to 24 fraction bits, ties away from zero
  logic signed [PX_W-1:0] px_b, py_b;
  logic signed [pgp_pkg::RAY_W-1:0] rx_r, ry_r;
  always_comb begin
    px_b = px_r + (px_r[PX_W-1] ? PX_W'(16'h7FFF) : PX_W'(16'h8000));
    py_b = py_r + (py_r[PX_W-1] ? PX_W'(16'h7FFF) : PX_W'(16'h8000));
  end
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      rx_r <= px_b[PX_W-1:16];
      ry_r <= py_b[PX_W-1:16];
    end
  end

  // stage 4: coefficient products for x and y columns
  logic signed [pgp_pkg::PROD_W-1:0] pcx_r [3];
  logic signed [pgp_pkg::PROD_W-1:0] pcy_r [3];
  logic [pgp_pkg::ROW_W-1:0] rows [3];
  assign rows[0] = cfg.rot_row0;
  assign rows[1] = cfg.rot_row1;
  assign rows[2] = cfg.rot_row2;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      for (int r = 0; r < 3; r++) begin
        pcx_r[r] <= pgp_pkg::field20(rows[r], 0) * rx_r;
        pcy_r[r] <= pgp_pkg::field20(rows[r], 1) * ry_r;
      end
    end
  end

  // stage 5: rotated ray; z column is coefficient times 1.0
  logic signed [pgp_pkg::A_W-1:0] a_r [3];
  logic signed [pgp_pkg::F_W-1:0] cz [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      cz[r] = pgp_pkg::field20(rows[r], 2);
    end
  end
  always_ff @(posedge clk) begin
    if (ld[4]) begin
      for (int r = 0; r < 3; r++) begin
        a_r[r] <= pgp_pkg::A_W'(pcx_r[r]) + pgp_pkg::A_W'(pcy_r[r])
                + $signed({{(pgp_pkg::A_W - pgp_pkg::F_W - 24){cz[r][pgp_pkg::F_W-1]}},
                           cz[r], 24'b0});
      end
    end
  end

  // stage 6: divider operands
  logic signed [pgp_pkg::F_W-1:0] wz;
  logic [pgp_pkg::A_W-1:0]        a2_neg;
  logic [pgp_pkg::F_W-1:0]        wz_neg;
  pgp_pkg::div_in_t               op_r;
  always_comb begin
    wz     = pgp_pkg::field20(cfg.world_offset, 2);
    a2_neg = -a_r[2];
    wz_neg = -wz;
  end
  always_ff @(posedge clk) begin
    if (ld[5]) begin
      op_r.num <= wz[pgp_pkg::F_W-1] ? wz_neg : wz;
      op_r.den <= a_r[2][pgp_pkg::A_W-1] ? a2_neg[pgp_pkg::DEN_W-1:0]
                                         : a_r[2][pgp_pkg::DEN_W-1:0];
      op_r.a0  <= a_r[0];
      op_r.a1  <= a_r[1];
      op_r.a2  <= a_r[2];
      op_r.neg <= (wz != '0) && (~wz[pgp_pkg::F_W-1] ^ a_r[2][pgp_pkg::A_W-1]);
      op_r.par <= (a_r[2] == '0);
    end
  end
  assign d_out = op_r;

endmodule

/* rtl/pgp_div.sv */
// Pipelined restoring divider, one quotient bit per stage: floor(num * 2^46 / den).
// Depends on pgp_pkg.
module pgp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  pgp_pkg::pipe_ctl_t ctl,
  input  logic               v_in,
  input  pgp_pkg::div_in_t   d_in,
  output logic               up_load,
  output logic               v_out,
  output pgp_pkg::div_st_t   d_out
);

  localparam int N = pgp_pkg::DIV_STEPS;

  logic [N-1:0] v_r, v_nxt, ld, v_prev, ld_next;

  assign ld      = {N{ctl.en}} | ~v_r;
  assign v_prev  = {v_r[N-2:0], v_in};
  assign ld_next = {ctl.down_load, ld[N-1:1]};
  assign v_nxt   = (ld & v_prev) | (~ld & ~ld_next);
  assign up_load = ld[0];
  assign v_out   = v_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  pgp_pkg::div_st_t st_r  [N];
  pgp_pkg::div_st_t prv_a [N];

  assign prv_a[0] = '{op: d_in, rem: '0, q: '0, ovf: 1'b0};

  for (genvar j = 0; j < N; j++) begin : g_step
    logic                   bit_in;
    logic [pgp_pkg::DEN_W:0] trial, diff;
    logic                   ge;
    pgp_pkg::div_st_t       nxt;

    if (j > 0) begin : g_link
      assign prv_a[j] = st_r[j-1];
    end

    // dividend bits enter only while the numerator lasts, zeros after
    if (j < pgp_pkg::NUM_W) begin : g_bit
      assign bit_in = prv_a[j].op.num[pgp_pkg::NUM_W-1-j];
    end else begin : g_zero
      assign bit_in = 1'b0;
    end

    always_comb begin
      trial   = {prv_a[j].rem, bit_in};
      diff    = trial - {1'b0, prv_a[j].op.den};
      ge      = trial >= {1'b0, prv_a[j].op.den};
      nxt.op  = prv_a[j].op;
      nxt.rem = ge ? diff[pgp_pkg::DEN_W-1:0] : trial[pgp_pkg::DEN_W-1:0];
      nxt.q   = {prv_a[j].q[pgp_pkg::Q_W-2:0], ge};
      nxt.ovf = prv_a[j].ovf | prv_a[j].q[pgp_pkg::Q_W-1];
    end

    always_ff @(posedge clk) begin
      if (ld[j]) begin
        st_r[j] <= nxt;
      end
    end
  end

  assign d_out = st_r[N-1];

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[N-1] && (st_r[N-1].op.den != '0) |-> (st_r[N-1].rem < st_r[N-1].op.den))
    else $error("divider remainder not below divisor");

endmodule

/* rtl/pgp_world.sv */
// Back pipeline: depth clamp, depth times rotated ray, rounding, offset add and saturation.
// Depends on pgp_pkg; its last stage is the block's output register.
module pgp_world (
  input  logic               clk,
  input  logic               rst_n,
  input  pgp_pkg::pipe_ctl_t ctl,
  input  pgp_pkg::cfg_t      cfg,
  input  logic               v_in,
  input  pgp_pkg::div_st_t   d_in,
  output logic               up_load,
  output logic               v_out,
  output pgp_pkg::out_word_t d_out
);

  localparam int N  = 4;
  localparam int LO = 31;
  localparam int PP_W = 32 + LO;
  localparam int P_W  = PP_W + LO;
  localparam int S_W  = pgp_pkg::M_W + 2;

  typedef struct packed {
    logic [31:0]                    dmag;
    logic signed [31:0]             depth;
    logic                           dsat;
    logic                           par;
    logic [2:0][pgp_pkg::DEN_W-1:0] amag;
    logic [2:0]                     pneg;
  } b1_t;

  typedef struct packed {
    logic [2:0][PP_W-1:0] plo;
    logic [2:0][PP_W-1:0] phi;
    logic signed [31:0]   depth;
    logic                 dsat;
    logic                 par;
    logic [2:0]           pneg;
  } b2_t;

  typedef struct packed {
    logic [2:0][pgp_pkg::M_W-1:0] m;
    logic signed [31:0]           depth;
    logic                         dsat;
    logic                         par;
    logic [2:0]                   pneg;
  } b3_t;

  logic [N-1:0] v_r, v_nxt, ld, v_prev, ld_next;

  assign ld      = {N{ctl.en}} | ~v_r;
  assign v_prev  = {v_r[N-2:0], v_in};
  assign ld_next = {ctl.down_load, ld[N-1:1]};
  assign v_nxt   = (ld & v_prev) | (~ld & ~ld_next);
  assign up_load = ld[0];
  assign v_out   = v_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // stage 1: clamp depth, take magnitudes of the rotated ray
  b1_t b1_nxt, b1_r;
  logic signed [pgp_pkg::A_W-1:0] av [3];
  logic [pgp_pkg::A_W-1:0]        an [3];
  logic                           over, dneg;
  logic [31:0]                    mag;
  always_comb begin
    av[0] = d_in.op.a0;
    av[1] = d_in.op.a1;
    av[2] = d_in.op.a2;
    if (d_in.op.neg) begin
      over = d_in.ovf | (d_in.q > 33'h080000000);
      mag  = over ? 32'h80000000 : d_in.q[31:0];
      dneg = over | (d_in.q != '0);
    end else begin
      over = d_in.ovf | (d_in.q > 33'h07FFFFFFF);
      mag  = over ? 32'h7FFFFFFF : d_in.q[31:0];
      dneg = 1'b0;
    end
    b1_nxt.dmag  = mag;
    b1_nxt.depth = dneg ? -$signed(mag) : $signed(mag);
    b1_nxt.dsat  = over;
    b1_nxt.par   = d_in.op.par;
    for (int i = 0; i < 3; i++) begin
      an[i]             = -av[i];
      b1_nxt.amag[i]    = av[i][pgp_pkg::A_W-1] ? an[i][pgp_pkg::DEN_W-1:0]
                                                : av[i][pgp_pkg::DEN_W-1:0];
      b1_nxt.pneg[i]    = dneg ^ av[i][pgp_pkg::A_W-1];
    end
  end
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      b1_r <= b1_nxt;
    end
  end

  // stage 2: 32 x 31 partial products
  b2_t b2_r;
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      for (int i = 0; i < 3; i++) begin
        b2_r.plo[i] <= PP_W'(b1_r.dmag) * PP_W'(b1_r.amag[i][LO-1:0]);
        b2_r.phi[i] <= PP_W'(b1_r.dmag) * PP_W'(b1_r.amag[i][pgp_pkg::DEN_W-1:LO]);
      end
      b2_r.depth <= b1_r.depth;
      b2_r.dsat  <= b1_r.dsat;
      b2_r.par   <= b1_r.par;
      b2_r.pneg  <= b1_r.pneg;
    end
  end

  // stage 3: join partials, round off 42 fraction bits
  b3_t b3_r;
  logic [P_W-1:0] psum [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psum[i] = {b2_r.phi[i], {LO{1'b0}}} + P_W'(b2_r.plo[i]) + (P_W'(1) << 41);
    end
  end
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      for (int i = 0; i < 3; i++) begin
        b3_r.m[i] <= psum[i][P_W-1:42];
      end
      b3_r.depth <= b2_r.depth;
      b3_r.dsat  <= b2_r.dsat;
      b3_r.par   <= b2_r.par;
      b3_r.pneg  <= b2_r.pneg;
    end
  end

  // stage 4: sign, add offset, saturate; parallel ray forces zeros
  pgp_pkg::out_word_t out_nxt, out_r;
  logic signed [S_W-1:0]           mext, sv, wext, s;
  logic signed [pgp_pkg::F_W-1:0]  w;
  logic [2:0]                      sat_i;
  logic [2:0][31:0]                res;
  always_comb begin
    mext = '0;
    sv   = '0;
    wext = '0;
    s    = '0;
    w    = '0;
    for (int i = 0; i < 3; i++) begin
      w        = pgp_pkg::field20(cfg.world_offset, i);
      mext     = $signed({2'b0, b3_r.m[i]});
      sv       = b3_r.pneg[i] ? -mext : mext;
      wext     = $signed({{(S_W - pgp_pkg::F_W - 4){w[pgp_pkg::F_W-1]}}, w, 4'b0});
      s        = sv + wext;
      // upper bits must all match the sign of a 32-bit value
      sat_i[i] = ~(&s[S_W-1:31]) & (|s[S_W-1:31]);
      res[i]   = sat_i[i] ? (s[S_W-1] ? 32'h80000000 : 32'h7FFFFFFF) : s[31:0];
    end
    if (b3_r.par) begin
      out_nxt = '0;
      out_nxt.parallel_ray = 1'b1;
    end else begin
      out_nxt.world_x      = res[0];
      out_nxt.world_y      = res[1];
      out_nxt.world_z      = res[2];
      out_nxt.ray_depth    = b3_r.depth;
      out_nxt.parallel_ray = 1'b0;
      out_nxt.saturated    = b3_r.dsat | (|sat_i);
    end
  end
  always_ff @(posedge clk) begin
    if (ld[3]) begin
      out_r <= out_nxt;
    end
  end
  assign d_out = out_r;

endmodule

/* rtl/pixel_to_ground_plane_projection_top.sv */
// Top level: configuration registers, handshake and the three pipeline sections.
// Depends on pgp_pkg, pgp_ray, pgp_div and pgp_world.
// Pipeline stages: 6 front, 66 divider, 4 back.
// Throughput: one word per cycle while the output is not stalled; the divider resolves one quotient bit per stage.
// Empty stages fill while the output is stalled, so input keeps flowing until the pipe is full.
// Reset (rst_n low, synchronous) clears all valid bits and loads the register defaults.
module pixel_to_ground_plane_projection_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  pgp_pkg::in_word_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output pgp_pkg::out_word_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pgp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pgp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  pgp_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= pgp_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        pgp_pkg::CFG_CENTER_X:     cfg_r.center_x     <= cfg_data[pgp_pkg::PIX_W-1:0];
        pgp_pkg::CFG_CENTER_Y:     cfg_r.center_y     <= cfg_data[pgp_pkg::PIX_W-1:0];
        pgp_pkg::CFG_INV_FOCAL_X:  cfg_r.inv_focal_x  <= cfg_data[pgp_pkg::FOC_W-1:0];
        pgp_pkg::CFG_INV_FOCAL_Y:  cfg_r.inv_focal_y  <= cfg_data[pgp_pkg::FOC_W-1:0];
        pgp_pkg::CFG_ROT_ROW0:     cfg_r.rot_row0     <= cfg_data[pgp_pkg::ROW_W-1:0];
        pgp_pkg::CFG_ROT_ROW1:     cfg_r.rot_row1     <= cfg_data[pgp_pkg::ROW_W-1:0];
        pgp_pkg::CFG_ROT_ROW2:     cfg_r.rot_row2     <= cfg_data[pgp_pkg::ROW_W-1:0];
        pgp_pkg::CFG_WORLD_OFFSET: cfg_r.world_offset <= cfg_data[pgp_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  logic               en;
  logic               ray_up, div_up, wld_up;
  logic               ray_v, div_v;
  pgp_pkg::div_in_t   ray_d;
  pgp_pkg::div_st_t   div_d;
  pgp_pkg::pipe_ctl_t ray_ctl, div_ctl, wld_ctl;

  // the whole pipe shifts when the output word leaves or the output is empty
  assign en = out_ready | ~out_valid;

  assign ray_ctl = '{en: en, down_load: div_up};
  assign div_ctl = '{en: en, down_load: wld_up};
  assign wld_ctl = '{en: en, down_load: out_ready};

  pgp_ray u_ray (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ray_ctl),
    .cfg     (cfg_r),
    .v_in    (in_valid),
    .d_in    (in_data),
    .up_load (ray_up),
    .v_out   (ray_v),
    .d_out   (ray_d)
  );

  pgp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (div_ctl),
    .v_in    (ray_v),
    .d_in    (ray_d),
    .up_load (div_up),
    .v_out   (div_v),
    .d_out   (div_d)
  );

  pgp_world u_world (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (wld_ctl),
    .cfg     (cfg_r),
    .v_in    (div_v),
    .d_in    (div_d),
    .up_load (wld_up),
    .v_out   (out_valid),
    .d_out   (out_data)
  );

  assign in_ready = ray_up;

  a_par_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.parallel_ray |->
      (out_data.world_x == '0) && (out_data.world_y == '0) && (out_data.world_z == '0)
      && (out_data.ray_depth == '0) && !out_data.saturated)
    else $error("parallel ray word carries nonzero values");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output stage is empty");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

endmodule

/* sim/tb.sv */
// Self-checking bench for pixel_to_ground_plane_projection_top: random and directed pixel words
// under several register settings, checked against a cycle-free fixed-point predictor.
// Depends on pgp_pkg and the top module in rtl/.
`timescale 1ns / 100ps

module tb;

  typedef logic signed [127:0] wide_t;

  localparam int    NUM_PHASES  = 12;
  localparam int    RAND_ITEMS  = 44;
  localparam int    DRAIN_WAIT  = 90;   // a bit over the pipe depth
  localparam int    STALL_LIMIT = 4000;
  localparam wide_t MAX32       = 2147483647;
  localparam wide_t MIN32       = -MAX32 - 1;

  class ground_board;
    pgp_pkg::cfg_t      regs;
    pgp_pkg::out_word_t pending_q[$];
    int                 errors, results, parallels, clamps, words;

    function new();
      regs = pgp_pkg::CFG_RESET;
    endfunction

    function void write_reg(logic [pgp_pkg::CFG_IDX_W-1:0] idx,
                            logic [pgp_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        pgp_pkg::CFG_CENTER_X:     regs.center_x     = d[pgp_pkg::PIX_W-1:0];
        pgp_pkg::CFG_CENTER_Y:     regs.center_y     = d[pgp_pkg::PIX_W-1:0];
        pgp_pkg::CFG_INV_FOCAL_X:  regs.inv_focal_x  = d[pgp_pkg::FOC_W-1:0];
        pgp_pkg::CFG_INV_FOCAL_Y:  regs.inv_focal_y  = d[pgp_pkg::FOC_W-1:0];
        pgp_pkg::CFG_ROT_ROW0:     regs.rot_row0     = d[pgp_pkg::ROW_W-1:0];
        pgp_pkg::CFG_ROT_ROW1:     regs.rot_row1     = d[pgp_pkg::ROW_W-1:0];
        pgp_pkg::CFG_ROT_ROW2:     regs.rot_row2     = d[pgp_pkg::ROW_W-1:0];
        pgp_pkg::CFG_WORLD_OFFSET: regs.world_offset = d[pgp_pkg::ROW_W-1:0];
        default: ;
      endcase
    endfunction

    function wide_t coef(logic [pgp_pkg::ROW_W-1:0] row, int k);
      wide_t c;
      c = $signed(row[pgp_pkg::F_W*k +: pgp_pkg::F_W]);
      return c;
    endfunction

    // nearest, ties away from zero
    function wide_t round16(wide_t x);
      wide_t m;
      m = ((x < 0 ? -x : x) + 32768) >> 16;
      return x < 0 ? -m : m;
    endfunction

    function wide_t clamp32(wide_t v, ref bit sat);
      if (v > MAX32) begin sat = 1; return MAX32; end
      if (v < MIN32) begin sat = 1; return MIN32; end
      return v;
    endfunction

    function pgp_pkg::out_word_t project(pgp_pkg::in_word_t px);
      wide_t     du, dv, rx, ry, q, dep, m, res;
      wide_t     a[3], w[3];
      logic [pgp_pkg::ROW_W-1:0] rows[3];
      bit        sat, neg, pneg;
      pgp_pkg::out_word_t o;
      du = wide_t'(px.pixel_u) - wide_t'(regs.center_x);
      dv = wide_t'(px.pixel_v) - wide_t'(regs.center_y);
      rx = round16(du * wide_t'(regs.inv_focal_x));
      ry = round16(dv * wide_t'(regs.inv_focal_y));
      rows[0] = regs.rot_row0;
      rows[1] = regs.rot_row1;
      rows[2] = regs.rot_row2;
      for (int i = 0; i < 3; i++) begin
        a[i] = coef(rows[i], 0) * rx + coef(rows[i], 1) * ry
             + coef(rows[i], 2) * (wide_t'(1) << 24);
        w[i] = coef(regs.world_offset, i);
      end
      o = '0;
      sat = 0;
      if (a[2] == 0) begin
        o.parallel_ray = 1'b1;
        return o;
      end
      q = ((w[2] < 0 ? -w[2] : w[2]) << 46) / (a[2] < 0 ? -a[2] : a[2]);
      if (q > (wide_t'(1) << 32)) q = (wide_t'(1) << 32) + 1;
      neg = ((w[2] > 0) != (a[2] < 0)) && w[2] != 0;
      if (neg) begin
        if (q > (wide_t'(1) << 31)) begin sat = 1; dep = MIN32; end
        else dep = -q;
      end else begin
        if (q > MAX32) begin sat = 1; dep = MAX32; end
        else dep = q;
      end
      for (int i = 0; i < 3; i++) begin
        m = ((dep < 0 ? -dep : dep) * (a[i] < 0 ? -a[i] : a[i]) + (wide_t'(1) << 41)) >> 42;
        pneg = (dep < 0) != (a[i] < 0);
        res = clamp32((pneg ? -m : m) + 16 * w[i], sat);
        case (i)
          0: o.world_x = res[31:0];
          1: o.world_y = res[31:0];
          default: o.world_z = res[31:0];
        endcase
      end
      o.ray_depth = dep[31:0];
      o.saturated = sat;
      return o;
    endfunction

    function void note(pgp_pkg::in_word_t px);
      pending_q = {pending_q, project(px)};
      words++;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t result %0d: %s got %h want %h", $time, results, what, got, want);
      errors++;
    endtask

    task check(pgp_pkg::out_word_t got);
      pgp_pkg::out_word_t want;
      if (pending_q.size() == 0) begin
        report("unexpected word", got.world_x, '0);
        return;
      end
      want = pending_q.pop_front();
      if (got.world_x !== want.world_x) report("world_x", got.world_x, want.world_x);
      if (got.world_y !== want.world_y) report("world_y", got.world_y, want.world_y);
      if (got.world_z !== want.world_z) report("world_z", got.world_z, want.world_z);
      if (got.ray_depth !== want.ray_depth) report("ray_depth", got.ray_depth, want.ray_depth);
      if (got.parallel_ray !== want.parallel_ray)
        report("parallel_ray", got.parallel_ray, want.parallel_ray);
      if (got.saturated !== want.saturated) report("saturated", got.saturated, want.saturated);
      parallels += want.parallel_ray;
      clamps += want.saturated;
      results++;
    endtask
  endclass

  logic                           clk = 0;
  logic                           rst_n = 0;
  logic                           in_valid = 0;
  logic                           in_ready;
  pgp_pkg::in_word_t              in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 0;
  pgp_pkg::out_word_t             out_data;
  logic                           cfg_valid = 0;
  logic                           cfg_ready;
  logic [pgp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pgp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  ground_board board = new();
  bit quiet = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;

  pixel_to_ground_plane_projection_top dut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: bursts of stall and of ready, steady ready at the end
  initial begin
    @(posedge clk);
    forever begin
      if (quiet || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  function automatic logic [pgp_pkg::ROW_W-1:0] pack3(int c0, int c1, int c2);
    return {c2[pgp_pkg::F_W-1:0], c1[pgp_pkg::F_W-1:0], c0[pgp_pkg::F_W-1:0]};
  endfunction

  function automatic logic [pgp_pkg::CFG_DATA_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task send_pixel(logic [pgp_pkg::PIX_W-1:0] u, logic [pgp_pkg::PIX_W-1:0] v);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{pixel_u: u, pixel_v: v};
    do @(posedge clk); while (!in_ready);
    board.note('{pixel_u: u, pixel_v: v});
  endtask

  task drain();
    in_valid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task write_reg(logic [pgp_pkg::CFG_IDX_W-1:0] idx, logic [pgp_pkg::CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, d);
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task write_all(logic [pgp_pkg::CFG_DATA_W-1:0] cx, logic [pgp_pkg::CFG_DATA_W-1:0] cy,
                 logic [pgp_pkg::CFG_DATA_W-1:0] fx, logic [pgp_pkg::CFG_DATA_W-1:0] fy,
                 logic [pgp_pkg::ROW_W-1:0] r0, logic [pgp_pkg::ROW_W-1:0] r1,
                 logic [pgp_pkg::ROW_W-1:0] r2, logic [pgp_pkg::ROW_W-1:0] wo);
    write_reg(pgp_pkg::CFG_CENTER_X, cx);
    write_reg(pgp_pkg::CFG_CENTER_Y, cy);
    write_reg(pgp_pkg::CFG_INV_FOCAL_X, fx);
    write_reg(pgp_pkg::CFG_INV_FOCAL_Y, fy);
    write_reg(pgp_pkg::CFG_ROT_ROW0, {4'($urandom_range(0, 15)), r0});
    write_reg(pgp_pkg::CFG_ROT_ROW1, {4'($urandom_range(0, 15)), r1});
    write_reg(pgp_pkg::CFG_ROT_ROW2, {4'($urandom_range(0, 15)), r2});
    write_reg(pgp_pkg::CFG_WORLD_OFFSET, {4'($urandom_range(0, 15)), wo});
  endtask

  // plausible pose: near-identity rows with a little random tilt
  function automatic logic [pgp_pkg::ROW_W-1:0] tilt_row(int k, int sgn);
    int c[3];
    for (int i = 0; i < 3; i++) c[i] = $urandom_range(0, 40000) - 20000;
    c[k] = sgn * 262144 + c[k] / 4;
    return pack3(c[0], c[1], c[2]);
  endfunction

  task set_phase(int ph);
    logic [pgp_pkg::ROW_W-1:0] wo;
    case (ph)
      0: ;  // reset values: every ray is parallel
      1: begin  // camera looking straight down, 2 m up
        write_all(64'd163798, 64'd131131, 64'd2677461, 64'd2676354, pack3(262144, 0, 0),
                  pack3(0, -262144, 0), pack3(0, 0, -262144), pack3(100, -50, 8192));
        write_reg(4'd9, rand64());   // beyond the register list: ignored
        write_reg(4'd15, '1);
      end
      2: write_reg(pgp_pkg::CFG_WORLD_OFFSET, 64'(pack3(-524288, 524287, 0)));  // zero height
      3: write_reg(pgp_pkg::CFG_WORLD_OFFSET, 64'(pack3(4096, 2048, -12000)));  // behind camera
      4: write_all('0, '0, '1, '1, pack3(-524288, 524287, -524288),
                   pack3(524287, -524288, 524287), pack3(0, 0, -1),
                   pack3(524287, -524288, 524287));  // huge depth, clamps
      5: write_all('0, '0, '0, '0, pack3(1, 1, 1), pack3(-1, -1, -1), pack3(0, 0, 1),
                   pack3(-524288, -524288, -524288));
      6: write_all('1, '1, '1, '1, '1, '1, '1, '1);
      default: begin
        wo = pack3($urandom_range(0, 1048575), $urandom_range(0, 1048575),
                   $urandom_range(1, 30000) * ($urandom_range(0, 1) ? 1 : -1));
        if ($urandom_range(0, 2) == 0)
          write_all(rand64(), rand64(), rand64(), rand64(),
                    pgp_pkg::ROW_W'(rand64()), pgp_pkg::ROW_W'(rand64()),
                    pgp_pkg::ROW_W'(rand64()), pgp_pkg::ROW_W'(rand64()));
        else
          write_all(pgp_pkg::CFG_DATA_W'($urandom_range(100000, 230000)),
                    pgp_pkg::CFG_DATA_W'($urandom_range(80000, 180000)),
                    pgp_pkg::CFG_DATA_W'($urandom_range(1000000, 6000000)),
                    pgp_pkg::CFG_DATA_W'($urandom_range(1000000, 6000000)),
                    tilt_row(0, 1), tilt_row(1, -1), tilt_row(2, -1), wo);
      end
    endcase
  endtask

  initial begin
    logic [pgp_pkg::PIX_W-1:0] u, v;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      set_phase(ph);
      if (ph == NUM_PHASES - 1) quiet = 1;
      if (ph < 7) begin
        send_pixel('0, '0);
        send_pixel('1, '1);
        send_pixel(board.regs.center_x, board.regs.center_y);
        if (ph == 1) begin
          send_pixel('0, '1);
          send_pixel('1, '0);
        end
      end
      for (int n = 0; n < RAND_ITEMS; n++) begin
        if (ph == 8 && n == RAND_ITEMS / 2) drain();  // let the pipe run dry once
        if ($urandom_range(0, 1) == 0) begin
          u = pgp_pkg::PIX_W'($urandom());
          v = pgp_pkg::PIX_W'($urandom());
        end else begin
          u = pgp_pkg::PIX_W'(board.regs.center_x + $urandom_range(0, 200000) - 100000);
          v = pgp_pkg::PIX_W'(board.regs.center_y + $urandom_range(0, 200000) - 100000);
        end
        send_pixel(u, v);
      end
    end
    drain();
    $display("covered %0d pixel words over %0d phases, %0d register writes",
             board.words, NUM_PHASES, cfg_writes);
    $display("checked %0d results: %0d parallel rays, %0d clamped",
             board.results, board.parallels, board.clamps);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/pgp_pkg.sv
rtl/pgp_ray.sv
rtl/pgp_div.sv
rtl/pgp_world.sv
rtl/pixel_to_ground_plane_projection_top.sv
sim/tb.sv
